[src/mdss_pkg.sv]
// Shared types and constants for the motor drive safety supervisor.
// No dependencies; imported by mdss_current, the top level, the drive checker and the testbench.
`default_nettype none

package mdss_pkg;

   // Item opcodes carried in req_tuser
   typedef enum logic [1:0] {
      OP_SUPERVISE = 2'd0,
      OP_SPEED     = 2'd1,
      OP_CLEAR     = 2'd2,
      OP_UNUSED    = 2'd3
   } opcode_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_PWM_FULL    = 3'd0,
      CSR_GAIN        = 3'd1,
      CSR_OFFSET      = 3'd2,
      CSR_MAX_CURRENT = 3'd3,
      CSR_TIMEOUT     = 3'd4,
      CSR_INVERT      = 3'd5,
      CSR_SPARE6      = 3'd6,
      CSR_SPARE7      = 3'd7
   } csr_index_type;

   // Field widths
   localparam int SPEED_W   = 16;
   localparam int ADC_W     = 12;
   localparam int ELAPSED_W = 10;
   localparam int PWM_W     = 16;
   localparam int CUR_W     = 19;
   localparam int GAIN_W    = 14;
   localparam int MA_W      = 18;
   localparam int WDOG_W    = 16;
   localparam int CSR_W     = 18;

   // Working width for signed current before saturation
   localparam int CUR_WORK_W = 21;
   localparam logic signed [CUR_WORK_W-1:0] CUR_SAT_POS = 21'sd262143;
   localparam logic signed [CUR_WORK_W-1:0] CUR_SAT_NEG = -21'sd262143;

   // Current measurement seen by the decision logic
   typedef struct packed {
      logic signed [CUR_W-1:0] current_ma;
      logic                    over_limit;
      logic                    inside_limit;
   } cur_status_type;

endpackage

`default_nettype wire

[src/mdss_current.sv]
// Current measurement: ADC scaling, offset, saturation and limit compare.
// Depends on mdss_pkg. Pure combinational logic.
`default_nettype none

module mdss_current
   import mdss_pkg::*;
#(
   parameter int ADC_BITS = 12
) (
   input  wire logic [ADC_W-1:0]  adc_sample,
   input  wire logic [GAIN_W-1:0] gain_q8,
   input  wire logic [MA_W-1:0]   offset_ma,
   input  wire logic [MA_W-1:0]   max_ma,
   output cur_status_type         status
);

   // Bits of the sample that are used
   localparam int ADC_USED = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
   localparam int PROD_W   = ADC_USED + GAIN_W + 1;
   localparam int SCALE_W  = PROD_W - 8;

   logic [ADC_USED-1:0]              adc_used;
   logic [PROD_W-1:0]                product;
   logic [SCALE_W-1:0]               scaled;
   logic signed [CUR_WORK_W-1:0]     diff;
   logic signed [CUR_WORK_W-1:0]     sat;
   logic signed [CUR_WORK_W-1:0]     lim;

   assign adc_used = adc_sample[ADC_USED-1:0];

   // Scale with round half up, then remove the zero offset
   assign product = PROD_W'(adc_used) * PROD_W'(gain_q8) + PROD_W'(128);
   assign scaled  = product[PROD_W-1:8];
   assign diff    = $signed(CUR_WORK_W'(scaled)) - $signed(CUR_WORK_W'(offset_ma));
   assign lim     = $signed(CUR_WORK_W'(max_ma));

   // Saturate to the reported range
   always_comb begin
      priority if (diff > CUR_SAT_POS) begin
         sat = CUR_SAT_POS;
      end else if (diff < CUR_SAT_NEG) begin
         sat = CUR_SAT_NEG;
      end else begin
         sat = diff;
      end
   end

   assign status.current_ma   = sat[CUR_W-1:0];
   assign status.over_limit   = (sat > lim) || (sat < -lim);
   assign status.inside_limit = (sat < lim) && (sat > -lim);

endmodule

`default_nettype wire

[src/motor_drive_safety_supervisor.sv]
// Motor drive safety supervisor, top level.
// Items pass from req accept through the input register and then the result register to rsp accept.
// Throughput: one item per cycle while the result side is not stalled; the drive, fault and watchdog state update
// in the same cycle the item moves from the input register to the result register.
// Reset: synchronous active high; clears state, item valids and restores
// configuration defaults.
`default_nettype none

module motor_drive_safety_supervisor
   import mdss_pkg::*;
#(
   parameter int ADC_BITS        = 12,
   parameter int SPEED_FRAC_BITS = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input item
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // speed_command[15:0], adc_sample[27:16],
                                        // elapsed_ms[37:28], zero pad
   input  wire logic [1:0]  req_tuser,  // opcode[1:0]
   // result item
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // pwm_level[15:0], reverse[16], fault[17],
                                        // current_ma[36:18], zero pad
   // configuration
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   localparam int MAG_W  = SPEED_FRAC_BITS + 1;
   localparam int LVL_PW = MAG_W + PWM_W;
   localparam logic signed [SPEED_W-1:0] FULL_POS = SPEED_W'(1 << SPEED_FRAC_BITS);
   localparam logic signed [SPEED_W-1:0] FULL_NEG = -FULL_POS;

   // Configuration registers
   logic [PWM_W-1:0]  pwm_full_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [MA_W-1:0]   offset_ff;
   logic [MA_W-1:0]   max_ff;
   logic [WDOG_W-1:0] timeout_ff;
   logic              invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_full_ff <= 16'd12500;
         gain_ff     <= 14'd6513;
         offset_ff   <= 18'd37879;
         max_ff      <= 18'd6000;
         timeout_ff  <= 16'd500;
         invert_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PWM_FULL:    pwm_full_ff <= csr_wdata[PWM_W-1:0];
            CSR_GAIN:        gain_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_OFFSET:      offset_ff   <= csr_wdata[MA_W-1:0];
            CSR_MAX_CURRENT: max_ff      <= csr_wdata[MA_W-1:0];
            CSR_TIMEOUT:     timeout_ff  <= csr_wdata[WDOG_W-1:0];
            CSR_INVERT:      invert_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Input register
   logic                      in_valid_ff;
   opcode_type                op_ff;
   logic signed [SPEED_W-1:0] speed_ff;
   logic [ADC_W-1:0]          adc_ff;
   logic [ELAPSED_W-1:0]      elapsed_ff;
   logic                      advance;

   assign advance    = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         op_ff      <= opcode_type'(req_tuser);
         speed_ff   <= $signed(req_tdata[15:0]);
         adc_ff     <= req_tdata[27:16];
         elapsed_ff <= req_tdata[37:28];
      end
   end

   // Current measurement
   cur_status_type cur;

   mdss_current #(
      .ADC_BITS(ADC_BITS)
   ) u_current (
      .adc_sample(adc_ff),
      .gain_q8   (gain_ff),
      .offset_ma (offset_ff),
      .max_ma    (max_ff),
      .status    (cur)
   );

   // Drive level from the commanded speed
   logic signed [SPEED_W-1:0] speed_clamp;
   logic signed [SPEED_W-1:0] speed_dir;
   logic [MAG_W-1:0]          mag;
   logic [LVL_PW-1:0]         lvl_prod;
   logic [PWM_W-1:0]          drive_level;
   logic                      drive_reverse;

   always_comb begin
      priority if (speed_ff > FULL_POS) begin
         speed_clamp = FULL_POS;
      end else if (speed_ff < FULL_NEG) begin
         speed_clamp = FULL_NEG;
      end else begin
         speed_clamp = speed_ff;
      end
   end

   assign speed_dir     = invert_ff ? -speed_clamp : speed_clamp;
   assign drive_reverse = speed_dir[SPEED_W-1];
   assign mag           = drive_reverse ? MAG_W'(-speed_dir) : MAG_W'(speed_dir);
   assign lvl_prod      = LVL_PW'(mag) * LVL_PW'(pwm_full_ff);
   assign drive_level   = lvl_prod[SPEED_FRAC_BITS +: PWM_W];

   // Supervisor state and its next value
   logic [PWM_W-1:0]  level_ff,   level_in;
   logic              reverse_ff, reverse_in;
   logic              fault_ff,   fault_in;
   logic [WDOG_W-1:0] ms_ff,      ms_in;

   // Watchdog advance, saturating
   logic [WDOG_W:0]   wdog_sum;
   logic [WDOG_W-1:0] wdog_adv;

   assign wdog_sum = (WDOG_W+1)'(ms_ff) + (WDOG_W+1)'(elapsed_ff);
   assign wdog_adv = wdog_sum[WDOG_W] ? {WDOG_W{1'b1}} : wdog_sum[WDOG_W-1:0];

   always_comb begin
      level_in   = level_ff;
      reverse_in = reverse_ff;
      fault_in   = fault_ff;
      ms_in      = wdog_adv;
      unique case (op_ff)
         OP_SPEED: begin
            ms_in = '0;
            if (!fault_ff) begin
               if (cur.over_limit) begin
                  level_in   = '0;
                  reverse_in = 1'b0;
                  fault_in   = 1'b1;
               end else begin
                  level_in   = drive_level;
                  reverse_in = drive_reverse;
               end
            end
         end
         OP_SUPERVISE: begin
            // timeout stop, then overcurrent stop and latch
            if (wdog_adv > timeout_ff || cur.over_limit) begin
               level_in   = '0;
               reverse_in = 1'b0;
            end
            if (cur.over_limit) begin
               fault_in = 1'b1;
            end
         end
         OP_CLEAR: begin
            if (cur.inside_limit) begin
               fault_in = 1'b0;
            end
         end
         OP_UNUSED: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         reverse_ff <= 1'b0;
         fault_ff   <= 1'b0;
         ms_ff      <= '0;
      end else if (advance) begin
         level_ff   <= level_in;
         reverse_ff <= reverse_in;
         fault_ff   <= fault_in;
         ms_ff      <= ms_in;
      end
   end

   // Result register
   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {3'b000, cur.current_ma, fault_in, reverse_in, level_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   a_fault_stops: assert property (@(posedge clock) disable iff (reset)
      fault_ff |-> (level_ff == '0) && !reverse_ff)
      else $error("drive active while fault latched");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !in_valid_ff)
      else $error("items valid after reset");

   a_cur_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[36:18] != 19'h40000)
      else $error("current outside saturation range");

endmodule

`default_nettype wire

[sim/mdss_drive_checker.sv]
// Drive status checker for the motor drive safety supervisor testbench.
// Watches the item, result and register ports, predicts each result and compares it.
// Depends on mdss_pkg for opcodes, register indexes and field widths.
`timescale 1ns / 1ps

module mdss_drive_checker
   import mdss_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [39:0]      req_tdata,  // speed_command[15:0], adc_sample[27:16],
                                             // elapsed_ms[37:28], zero pad
   input  wire logic [1:0]       req_tuser,  // opcode[1:0]
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [39:0]      rsp_tdata,  // pwm_level[15:0], reverse[16], fault[17],
                                             // current_ma[36:18], zero pad
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   localparam longint CUR_CLAMP   = 262143;
   localparam longint FULL_SPEED  = 16384;
   localparam int     SPEED_FRAC  = 14;
   localparam longint WDOG_MAX    = 65535;
   localparam int     REPORT_MAX  = 10;

   typedef struct packed {
      logic [PWM_W-1:0]        pwm_level;
      logic                    reverse;
      logic                    fault;
      logic signed [CUR_W-1:0] current_ma;
   } drive_status_type;

   // register copy
   logic [15:0]       pwm_full;
   logic [GAIN_W-1:0] gain_q8;
   logic [MA_W-1:0]   offset_ma;
   logic [MA_W-1:0]   max_ma;
   logic [15:0]       timeout_ms;
   logic              invert;

   // drive state copy
   logic [PWM_W-1:0]  level;
   logic              rev;
   logic              fault_latched;
   logic [WDOG_W-1:0] wdog_ms;

   drive_status_type predicted_drive_q[$];
   int mismatches = 0;

   assign fail_count = mismatches;

   // sensor sample to saturated milliamps
   function automatic longint sense_current(logic [ADC_W-1:0] adc);
      longint scaled;
      longint cur;
      scaled = (longint'(adc) * longint'(gain_q8) + 128) >>> 8;
      cur = scaled - longint'(offset_ma);
      if (cur > CUR_CLAMP) cur = CUR_CLAMP;
      if (cur < -CUR_CLAMP) cur = -CUR_CLAMP;
      return cur;
   endfunction

   // apply one item to the state copy and return the status it leaves
   function automatic drive_status_type step_drive(opcode_type op,
                                                   logic signed [SPEED_W-1:0] speed,
                                                   logic [ADC_W-1:0] adc,
                                                   logic [ELAPSED_W-1:0] elapsed);
      longint cur;
      longint lim;
      longint spd;
      longint mag;
      longint wd;
      logic over;
      drive_status_type res;
      cur = sense_current(adc);
      lim = longint'(max_ma);
      over = (cur > lim) || (cur < -lim);
      if (op != OP_SPEED) begin
         wd = longint'(wdog_ms) + longint'(elapsed);
         wdog_ms = (wd > WDOG_MAX) ? WDOG_MAX[15:0] : wd[15:0];
      end
      case (op)
         OP_SPEED: begin
            wdog_ms = '0;
            if (!fault_latched) begin
               if (over) begin
                  level = '0;
                  rev = 1'b0;
                  fault_latched = 1'b1;
               end else begin
                  spd = longint'(speed);
                  if (spd > FULL_SPEED) spd = FULL_SPEED;
                  if (spd < -FULL_SPEED) spd = -FULL_SPEED;
                  if (invert) spd = -spd;
                  rev = (spd < 0);
                  mag = rev ? -spd : spd;
                  wd = (mag * longint'(pwm_full)) >>> SPEED_FRAC;
                  level = wd[PWM_W-1:0];
               end
            end
         end
         OP_SUPERVISE: begin
            // watchdog stop first, then the overcurrent check
            if (longint'(wdog_ms) > longint'(timeout_ms)) begin
               level = '0;
               rev = 1'b0;
            end
            if (over) begin
               level = '0;
               rev = 1'b0;
               fault_latched = 1'b1;
            end
         end
         OP_CLEAR: begin
            // strict inside the limit only
            if (cur < lim && cur > -lim) fault_latched = 1'b0;
         end
         default: ;
      endcase
      res.pwm_level = level;
      res.reverse = rev;
      res.fault = fault_latched;
      res.current_ma = cur[CUR_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin : track
      drive_status_type want;
      drive_status_type got;
      if (reset) begin
         pwm_full = 16'd12500;
         gain_q8 = 14'd6513;
         offset_ma = 18'd37879;
         max_ma = 18'd6000;
         timeout_ms = 16'd500;
         invert = 1'b0;
         level = '0;
         rev = 1'b0;
         fault_latched = 1'b0;
         wdog_ms = '0;
         predicted_drive_q.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_PWM_FULL:    pwm_full = csr_wdata[15:0];
               CSR_GAIN:        gain_q8 = csr_wdata[GAIN_W-1:0];
               CSR_OFFSET:      offset_ma = csr_wdata[MA_W-1:0];
               CSR_MAX_CURRENT: max_ma = csr_wdata[MA_W-1:0];
               CSR_TIMEOUT:     timeout_ms = csr_wdata[15:0];
               CSR_INVERT:      invert = csr_wdata[0];
               default: ;
            endcase
         end

         // result side
         if (rsp_tvalid && rsp_tready) begin
            got.pwm_level = rsp_tdata[15:0];
            got.reverse = rsp_tdata[16];
            got.fault = rsp_tdata[17];
            got.current_ma = rsp_tdata[36:18];
            if (predicted_drive_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: result with no item outstanding: level %0d rev %0b fault %0b cur %0d",
                           $realtime, got.pwm_level, got.reverse, got.fault, got.current_ma);
            end else begin
               want = predicted_drive_q.pop_front();
               if (got.pwm_level !== want.pwm_level || got.reverse !== want.reverse ||
                   got.fault !== want.fault || got.current_ma !== want.current_ma) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("%0t: expected level %0d rev %0b fault %0b cur %0d, got level %0d rev %0b fault %0b cur %0d",
                              $realtime, want.pwm_level, want.reverse, want.fault,
                              want.current_ma, got.pwm_level, got.reverse, got.fault,
                              got.current_ma);
               end
            end
         end

         // item side
         if (req_tvalid && req_tready)
            predicted_drive_q.push_back(step_drive(opcode_type'(req_tuser), req_tdata[15:0],
                                                   req_tdata[27:16], req_tdata[37:28]));
      end
      pending <= predicted_drive_q.size();
   end

endmodule

[sim/tb_motor_drive_safety_supervisor.sv]
// Testbench top for the motor drive safety supervisor: clock, reset, stimulus and verdict.
// Depends on mdss_pkg, the supervisor RTL and mdss_drive_checker, which does the checking.
`timescale 1ns / 1ps

module tb_motor_drive_safety_supervisor;
   import mdss_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES  = 250;
   localparam int FULL_SPEED   = 16384;
   localparam int ELAPSED_MAX  = 1023;
   localparam int ADC_MAX      = 4095;
   localparam int ADC_NEAR_ZERO = 1489;   // about 3 mA with reset gain and offset

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [39:0]      req_tdata = '0;
   logic [1:0]       req_tuser = OP_SUPERVISE;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [39:0]      rsp_tdata;
   logic             csr_we = 1'b0;
   logic [2:0]       csr_index = CSR_PWM_FULL;
   logic [CSR_W-1:0] csr_wdata = '0;
   int               fail_count;
   int               pending;

   // register values as last written, used to aim sensor samples at the limit
   int unsigned cfg_gain = 6513;
   int unsigned cfg_offset = 37879;
   int unsigned cfg_max = 6000;

   motor_drive_safety_supervisor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mdss_drive_checker drive_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin : run_limit
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random stalls, plus long hold-offs after some results
   initial begin : result_sink
      int taken;
      int next_hold_at;
      int hold_left;
      int stall_left;
      int run_left;
      int r;
      taken = 0;
      next_hold_at = 400;
      hold_left = 0;
      stall_left = 0;
      run_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) taken++;
         if (taken >= next_hold_at) begin
            next_hold_at += 500;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (run_left > 0) begin
               run_left--;
            end else begin
               run_left = $urandom_range(0, 40);
               r = $urandom_range(0, 99);
               stall_left = (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [SPEED_W-1:0] pick_speed();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r < 2) begin
         case ($urandom_range(0, 8))
            0: v = FULL_SPEED;
            1: v = -FULL_SPEED;
            2: v = 32767;
            3: v = -32768;
            4: v = 0;
            5: v = 1;
            6: v = -1;
            7: v = FULL_SPEED + 1;
            default: v = -FULL_SPEED - 1;
         endcase
      end else if (r < 6) begin
         v = int'($urandom_range(0, 2 * FULL_SPEED)) - FULL_SPEED;
      end else begin
         v = $urandom;
      end
      return v[SPEED_W-1:0];
   endfunction

   // mostly around the zero point and the limit, the rest anywhere
   function automatic logic [ADC_W-1:0] pick_adc();
      longint center;
      longint band;
      longint v;
      if ($urandom_range(0, 99) < 30) return $urandom_range(0, ADC_MAX);
      center = (cfg_gain == 0) ? 2048 : (longint'(cfg_offset) * 256) / cfg_gain;
      band = (cfg_gain == 0) ? 16 : (longint'(cfg_max) * 256) / cfg_gain + 2;
      if (band > ADC_MAX) band = ADC_MAX;
      v = center - band - 2 + longint'($urandom_range(0, 2 * band + 4));
      if (v < 0) v = 0;
      if (v > ADC_MAX) v = ADC_MAX;
      return v[ADC_W-1:0];
   endfunction

   function automatic logic [ELAPSED_W-1:0] pick_elapsed(bit long_waits);
      int r;
      r = $urandom_range(0, 99);
      if (long_waits && r < 60) return ELAPSED_MAX;
      if (r < 50) return $urandom_range(0, 20);
      if (r < 85) return $urandom_range(0, ELAPSED_MAX);
      return ELAPSED_MAX;
   endfunction

   task automatic send_item(opcode_type op, logic [SPEED_W-1:0] speed, logic [ADC_W-1:0] adc,
                            logic [ELAPSED_W-1:0] elapsed, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {2'b00, elapsed, adc, speed};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and wait until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_W-1:0];
      @(posedge clock);
   endtask

   task automatic apply_settings(int unsigned pwm, int unsigned gain, int unsigned offset,
                                 int unsigned max_ma, int unsigned timeout, int unsigned inv);
      write_reg(CSR_PWM_FULL, pwm);
      write_reg(CSR_GAIN, gain);
      write_reg(CSR_OFFSET, offset);
      write_reg(CSR_MAX_CURRENT, max_ma);
      write_reg(CSR_TIMEOUT, timeout);
      write_reg(CSR_INVERT, inv);
      csr_we <= 1'b0;
      @(posedge clock);
      cfg_gain = gain;
      cfg_offset = offset;
      cfg_max = max_ma;
   endtask

   task automatic run_phase(int count, int speed_pct, bit long_waits, bit gaps_on,
                            bit pause_mid);
      int r;
      opcode_type op;
      for (int i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2) drain();
         r = $urandom_range(0, 99);
         op = (r < speed_pct) ? OP_SPEED : (r < 85) ? OP_SUPERVISE :
              (r < 97) ? OP_CLEAR : OP_UNUSED;
         send_item(op, pick_speed(), pick_adc(), pick_elapsed(long_waits),
                   gaps_on ? pick_gap() : 0);
      end
   endtask

   // a random setting with the zero point inside the sensor range
   task automatic apply_random_settings();
      int unsigned gain;
      int unsigned offset;
      gain = $urandom_range(1000, 16383);
      offset = (gain * $urandom_range(0, ADC_MAX)) / 256;
      apply_settings($urandom_range(1, 65535), gain, offset,
                     $urandom_range(0, (gain * 64) / 256), $urandom_range(0, 3000),
                     $urandom_range(0, 1));
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: drive range, clamping, watchdog, fault latch and clear
      send_item(OP_SPEED, FULL_SPEED, ADC_NEAR_ZERO, 0, pick_gap());
      send_item(OP_SPEED, -FULL_SPEED, ADC_NEAR_ZERO, 0, pick_gap());
      send_item(OP_SPEED, 16'sh7FFF, ADC_NEAR_ZERO, 0, pick_gap());
      send_item(OP_SPEED, 16'sh8000, ADC_NEAR_ZERO, 0, pick_gap());
      send_item(OP_SPEED, FULL_SPEED / 2, ADC_NEAR_ZERO, 0, pick_gap());
      send_item(OP_SUPERVISE, 0, ADC_NEAR_ZERO, ELAPSED_MAX, pick_gap());
      send_item(OP_UNUSED, 16'hFFFF, ADC_MAX, ELAPSED_MAX, pick_gap());
      send_item(OP_SPEED, 100, ADC_MAX, 0, pick_gap());
      send_item(OP_SPEED, FULL_SPEED, ADC_NEAR_ZERO, 0, pick_gap());
      send_item(OP_CLEAR, 0, 0, 1, pick_gap());
      send_item(OP_CLEAR, 0, ADC_NEAR_ZERO, 1, pick_gap());
      send_item(OP_SPEED, FULL_SPEED, ADC_NEAR_ZERO, ELAPSED_MAX, pick_gap());
      send_item(OP_SUPERVISE, 0, 0, 0, pick_gap());
      send_item(OP_CLEAR, 0, ADC_NEAR_ZERO, 0, pick_gap());
      drain();

      // unit gain: current equals sample minus 2000, limit of 1000, inverted, zero timeout
      apply_settings(65535, 256, 2000, 1000, 0, 1);
      send_item(OP_SPEED, FULL_SPEED, 3000, 0, pick_gap());
      send_item(OP_SPEED, 16'hFFFF, 1000, 0, pick_gap());
      send_item(OP_SUPERVISE, 0, 2000, 0, pick_gap());
      send_item(OP_SUPERVISE, 0, 2000, 1, pick_gap());
      send_item(OP_SPEED, FULL_SPEED, 3001, 0, pick_gap());
      send_item(OP_CLEAR, 0, 3000, 0, pick_gap());
      send_item(OP_CLEAR, 0, 999, 0, pick_gap());
      send_item(OP_CLEAR, 0, 2999, 0, pick_gap());
      send_item(OP_SUPERVISE, 0, 1000, 5, pick_gap());
      drain();

      // random items under several settings
      apply_settings(12500, 6513, 37879, 6000, 500, 0);
      run_phase(200, 40, 1'b0, 1'b1, 1'b0);
      drain();
      // upper extremes; watchdog runs into saturation with the largest timeout
      apply_settings(65535, 16383, 262143, 262143, 65535, 1);
      run_phase(200, 1, 1'b1, 1'b1, 1'b1);
      drain();
      // lower extremes, zero full count, no gaps
      apply_settings(0, 0, 0, 0, 0, 0);
      run_phase(100, 40, 1'b0, 1'b0, 1'b0);
      drain();
      apply_settings(1, 1, 0, 1, 1, 1);
      run_phase(100, 40, 1'b0, 1'b1, 1'b0);
      drain();
      for (int p = 0; p < 4; p++) begin
         apply_random_settings();
         run_phase(175, 40, 1'b0, p != 2, 1'b0);
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[filelist.f]
src/mdss_pkg.sv
src/mdss_current.sv
src/motor_drive_safety_supervisor.sv
sim/mdss_drive_checker.sv
sim/tb_motor_drive_safety_supervisor.sv
